>>> sv/billboard_quad_expander_assert.svh
// assertion macros for the billboard quad expander
`ifndef BILLBOARD_QUAD_EXPANDER_ASSERT_SVH
`define BILLBOARD_QUAD_EXPANDER_ASSERT_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define BQE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition must never be true outside reset
`define BQE_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define BQE_ASSERT(lbl, clk, rst_n, prop, msg)
`define BQE_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

>>> sv/bqe_pkg.sv
// shared types, widths and constants of the billboard quad expander
`default_nettype none
package bqe_pkg;

    localparam int unsigned AXES       = 3;
    localparam int unsigned VEC_W      = 16;
    localparam int unsigned POS_W      = 32;
    localparam int unsigned TEX_W      = 16;
    localparam int unsigned RAD_W      = 31;
    localparam int unsigned RAD_LO_W   = 16;
    localparam int unsigned CLR_W      = 32;
    localparam int unsigned PROD_W     = 2 * VEC_W;
    localparam int unsigned SUM_W      = PROD_W + 1;
    localparam int unsigned PLO_W      = SUM_W + RAD_LO_W + 1;
    localparam int unsigned PHI_W      = SUM_W + RAD_W - RAD_LO_W + 1;
    localparam int unsigned FULL_W     = 64;
    localparam int unsigned RND_SH     = 30;
    localparam int unsigned BAS_W      = FULL_W - RND_SH;
    localparam int unsigned QSUM_W     = BAS_W + 1;
    localparam int unsigned EXT_W      = QSUM_W + 1;
    localparam int unsigned BAS_STAGES = 4;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CORNER_W   = 2;

    localparam logic [FULL_W-1:0]   RND_HALF    = FULL_W'(1) << (RND_SH - 1);
    localparam logic [CORNER_W-1:0] CORNER_LAST = {CORNER_W{1'b1}};
    localparam logic [POS_W-1:0]    POS_MAX     = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic [POS_W-1:0]    POS_MIN     = {1'b1, {(POS_W-1){1'b0}}};

    typedef logic signed [VEC_W-1:0] t_vec;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOP_X   = 3'd0,
        CFG_TOP_Y   = 3'd1,
        CFG_TOP_Z   = 3'd2,
        CFG_RIGHT_X = 3'd3,
        CFG_RIGHT_Y = 3'd4,
        CFG_RIGHT_Z = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        t_vec [AXES-1:0] top;
        t_vec [AXES-1:0] right;
    } t_cam;

    // top = (0, max, 0), right = (max, 0, 0); index 0 is x
    localparam t_cam CAM_RST = '{
        top:   {16'sd0, 16'sd32767, 16'sd0},
        right: {16'sd0, 16'sd0, 16'sd32767}
    };

    typedef struct packed {
        logic [AXES-1:0][POS_W-1:0] pos;
        logic [TEX_W-1:0]           tex_left;
        logic [TEX_W-1:0]           tex_top;
        logic [TEX_W-1:0]           tex_right;
        logic [TEX_W-1:0]           tex_bottom;
        logic [CLR_W-1:0]           color;
    } t_side;

    typedef struct packed {
        t_side                      side;
        logic [AXES-1:0][BAS_W-1:0] vr;
        logic [AXES-1:0][BAS_W-1:0] vt;
    } t_basis;

    // clamp a wide signed sum to the 32 bit coordinate range
    function automatic logic [POS_W-1:0] sat_pos(input logic signed [EXT_W-1:0] v);
        logic same;
        same = (v[EXT_W-1:POS_W-1] == {(EXT_W-POS_W+1){1'b0}}) ||
               (v[EXT_W-1:POS_W-1] == {(EXT_W-POS_W+1){1'b1}});
        if (same) begin
            return v[POS_W-1:0];
        end
        return v[EXT_W-1] ? POS_MIN : POS_MAX;
    endfunction

endpackage
`default_nettype wire

>>> sv/bqe_basis.sv
// four stage pipeline forming the rotated, scaled basis vectors vr and vt
`default_nettype none
module bqe_basis import bqe_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  t_side            i_side,
    input  logic [RAD_W-1:0] i_half_width,
    input  logic [RAD_W-1:0] i_half_height,
    input  t_vec             i_sin,
    input  t_vec             i_cos,
    input  t_cam             i_cam,
    output logic             o_ready,
    output logic             o_valid,
    output t_basis           o_basis,
    input  logic             i_ready
);

    logic [BAS_STAGES-1:0] r_vld;
    logic [BAS_STAGES-1:0] en;

    // stage 1: the four q2.30 products of q1.15 operands per axis
    t_side                     r_s1_side;
    logic [RAD_W-1:0]          r_s1_rw, r_s1_rh;
    logic signed [PROD_W-1:0]  r_s1_st [AXES];
    logic signed [PROD_W-1:0]  r_s1_cr [AXES];
    logic signed [PROD_W-1:0]  r_s1_ct [AXES];
    logic signed [PROD_W-1:0]  r_s1_sr [AXES];

    // stage 2: direction sums in q3.30
    t_side                     r_s2_side;
    logic [RAD_W-1:0]          r_s2_rw, r_s2_rh;
    logic signed [SUM_W-1:0]   r_s2_r [AXES];
    logic signed [SUM_W-1:0]   r_s2_t [AXES];
    logic signed [SUM_W-1:0]   n_s2_r [AXES];
    logic signed [SUM_W-1:0]   n_s2_t [AXES];

    // stage 3: partial products against the radius halves
    t_side                     r_s3_side;
    logic signed [PLO_W-1:0]   r_s3_rlo [AXES];
    logic signed [PHI_W-1:0]   r_s3_rhi [AXES];
    logic signed [PLO_W-1:0]   r_s3_tlo [AXES];
    logic signed [PHI_W-1:0]   r_s3_thi [AXES];

    // stage 4: recombined and rounded basis components
    t_side                     r_s4_side;
    logic [AXES-1:0][BAS_W-1:0] r_s4_vr, r_s4_vt;
    logic [AXES-1:0][BAS_W-1:0] n_s4_vr, n_s4_vt;
    logic signed [FULL_W-1:0]  full_r [AXES];
    logic signed [FULL_W-1:0]  full_t [AXES];

    always_comb begin
        en[BAS_STAGES-1] = !r_vld[BAS_STAGES-1] || i_ready;
        for (int k = BAS_STAGES - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_ready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < BAS_STAGES; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            n_s2_r[i] = SUM_W'(r_s1_st[i]) + SUM_W'(r_s1_cr[i]);
            n_s2_t[i] = SUM_W'(r_s1_ct[i]) - SUM_W'(r_s1_sr[i]);
            full_r[i] = (FULL_W'(r_s3_rhi[i]) <<< RAD_LO_W) + FULL_W'(r_s3_rlo[i])
                        + $signed(RND_HALF);
            full_t[i] = (FULL_W'(r_s3_thi[i]) <<< RAD_LO_W) + FULL_W'(r_s3_tlo[i])
                        + $signed(RND_HALF);
            n_s4_vr[i] = full_r[i][FULL_W-1:RND_SH];
            n_s4_vt[i] = full_t[i][FULL_W-1:RND_SH];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_s1_side <= i_side;
            r_s1_rw   <= i_half_width;
            r_s1_rh   <= i_half_height;
            for (int i = 0; i < AXES; i++) begin
                r_s1_st[i] <= $signed(i_sin) * $signed(i_cam.top[i]);
                r_s1_cr[i] <= $signed(i_cos) * $signed(i_cam.right[i]);
                r_s1_ct[i] <= $signed(i_cos) * $signed(i_cam.top[i]);
                r_s1_sr[i] <= $signed(i_sin) * $signed(i_cam.right[i]);
            end
        end
        if (en[1]) begin
            r_s2_side <= r_s1_side;
            r_s2_rw   <= r_s1_rw;
            r_s2_rh   <= r_s1_rh;
            r_s2_r    <= n_s2_r;
            r_s2_t    <= n_s2_t;
        end
        if (en[2]) begin
            r_s3_side <= r_s2_side;
            for (int i = 0; i < AXES; i++) begin
                r_s3_rlo[i] <= r_s2_r[i] * $signed({1'b0, r_s2_rw[RAD_LO_W-1:0]});
                r_s3_rhi[i] <= r_s2_r[i] * $signed({1'b0, r_s2_rw[RAD_W-1:RAD_LO_W]});
                r_s3_tlo[i] <= r_s2_t[i] * $signed({1'b0, r_s2_rh[RAD_LO_W-1:0]});
                r_s3_thi[i] <= r_s2_t[i] * $signed({1'b0, r_s2_rh[RAD_W-1:RAD_LO_W]});
            end
        end
        if (en[3]) begin
            r_s4_side <= r_s3_side;
            r_s4_vr   <= n_s4_vr;
            r_s4_vt   <= n_s4_vt;
        end
    end

    assign o_valid       = r_vld[BAS_STAGES-1];
    assign o_basis.side  = r_s4_side;
    assign o_basis.vr    = r_s4_vr;
    assign o_basis.vt    = r_s4_vt;

endmodule
`default_nettype wire

>>> sv/bqe_emit.sv
// corner stage: holds one quad and sends its four vertices, one per cycle
`default_nettype none
`include "billboard_quad_expander_assert.svh"
module bqe_emit import bqe_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  t_basis              i_basis,
    output logic                o_ready,
    output logic                o_valid,
    output logic [POS_W-1:0]    o_vert_x,
    output logic [POS_W-1:0]    o_vert_y,
    output logic [POS_W-1:0]    o_vert_z,
    output logic [CLR_W-1:0]    o_vert_color,
    output logic [TEX_W-1:0]    o_vert_u,
    output logic [TEX_W-1:0]    o_vert_v,
    output logic [CORNER_W-1:0] o_corner_index,
    output logic                o_last_corner
);

    logic                        r_vld5;
    logic [CORNER_W-1:0]         r_corner;
    t_side                       r_side;
    logic signed [QSUM_W-1:0]    r_sum [AXES];
    logic signed [QSUM_W-1:0]    r_dif [AXES];
    logic signed [QSUM_W-1:0]    n_sum [AXES];
    logic signed [QSUM_W-1:0]    n_dif [AXES];

    logic                        r_out_vld;
    logic [AXES-1:0][POS_W-1:0]  r_vert;
    logic [AXES-1:0][POS_W-1:0]  n_vert;
    logic [CLR_W-1:0]            r_color;
    logic [TEX_W-1:0]            r_u, r_v;
    logic [CORNER_W-1:0]         r_corner_out;
    logic                        r_last;

    logic signed [QSUM_W-1:0]    sel [AXES];
    logic signed [EXT_W-1:0]     wide [AXES];

    // free when empty or when the last corner goes out this cycle
    assign o_ready = !r_vld5 || (r_corner == CORNER_LAST);

    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            n_sum[i] = QSUM_W'($signed(i_basis.vt[i])) + QSUM_W'($signed(i_basis.vr[i]));
            n_dif[i] = QSUM_W'($signed(i_basis.vt[i])) - QSUM_W'($signed(i_basis.vr[i]));
            // vt and vr same sign -> sum, else difference; bit 0 gives the sign
            sel[i]  = (r_corner[0] == r_corner[1]) ? r_sum[i] : r_dif[i];
            wide[i] = EXT_W'($signed(r_side.pos[i]))
                      + (r_corner[0] ? EXT_W'(sel[i]) : -EXT_W'(sel[i]));
            n_vert[i] = sat_pos(wide[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld5    <= 1'b0;
            r_corner  <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_ready) begin
                r_vld5 <= i_valid;
            end
            if (r_vld5) begin
                r_corner <= r_corner + CORNER_W'(1);
            end
            r_out_vld <= r_vld5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_side <= i_basis.side;
            r_sum  <= n_sum;
            r_dif  <= n_dif;
        end
        r_vert       <= n_vert;
        r_color      <= r_side.color;
        r_u          <= r_corner[1] ? r_side.tex_right : r_side.tex_left;
        r_v          <= r_corner[0] ? r_side.tex_top : r_side.tex_bottom;
        r_corner_out <= r_corner;
        r_last       <= (r_corner == CORNER_LAST);
    end

    assign o_valid        = r_out_vld;
    assign o_vert_x       = r_vert[0];
    assign o_vert_y       = r_vert[1];
    assign o_vert_z       = r_vert[2];
    assign o_vert_color   = r_color;
    assign o_vert_u       = r_u;
    assign o_vert_v       = r_v;
    assign o_corner_index = r_corner_out;
    assign o_last_corner  = r_last;

    `BQE_ASSERT(a_quad_unbroken, i_clk, i_rst_n, r_out_vld && !r_last |=> r_out_vld && (r_corner_out == $past(r_corner_out) + 2'd1), "quad vertices not consecutive")
    `BQE_ASSERT(a_color_held, i_clk, i_rst_n, r_out_vld && !r_last |=> $stable(r_color), "color changed inside a quad")
    `BQE_ASSERT(a_quad_restart, i_clk, i_rst_n, r_out_vld && r_last |=> !r_out_vld || (r_corner_out == '0), "new quad does not start at corner zero")

endmodule
`default_nettype wire

>>> sv/billboard_quad_expander.sv
// top level of the camera facing billboard quad expander
`default_nettype none
// Billboard quad expander. Each particle word is taken at a clock edge with start high
// and busy low; four vertex words follow, one per cycle with o_valid high, in the order
// bottom-left, top-left, bottom-right, top-right (o_corner_index 0..3, o_last_corner on
// the fourth). The receiver cannot hold results off, so the block never lets vertices
// pile up: busy is high while all four basis stages are full and the corner stage
// cannot take a particle. With nothing waiting ahead of it, a particle passes through
// the four basis stages, the corner stage and the output register. The sustained rate
// is set by the single vertex output; up to six particles are in flight (four in the
// basis stages, one in the corner stage and the last vertex of one more in the output
// register), so start may be held high and particles go in back to back as fast as
// the output drains them. Camera top and right vectors are written through i_cfg_we /
// i_cfg_index / i_cfg_data (index 0..5 = top x,y,z then right x,y,z, other indexes
// ignored); the user must write them only while nothing is in flight, which the block
// does not enforce. Coordinates are q16.16 and saturate to the signed 32 bit range.
module billboard_quad_expander import bqe_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // particle input
    input  logic                 start,
    output logic                 busy,
    input  logic [POS_W-1:0]     i_pos_x,
    input  logic [POS_W-1:0]     i_pos_y,
    input  logic [POS_W-1:0]     i_pos_z,
    input  logic [TEX_W-1:0]     i_tex_left,
    input  logic [TEX_W-1:0]     i_tex_top,
    input  logic [TEX_W-1:0]     i_tex_right,
    input  logic [TEX_W-1:0]     i_tex_bottom,
    input  logic [RAD_W-1:0]     i_half_width,
    input  logic [RAD_W-1:0]     i_half_height,
    input  logic [CLR_W-1:0]     i_color,
    input  logic [VEC_W-1:0]     i_sin_angle,
    input  logic [VEC_W-1:0]     i_cos_angle,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [VEC_W-1:0]     i_cfg_data,
    // vertex output
    output logic                 o_valid,
    output logic [POS_W-1:0]     o_vert_x,
    output logic [POS_W-1:0]     o_vert_y,
    output logic [POS_W-1:0]     o_vert_z,
    output logic [CLR_W-1:0]     o_vert_color,
    output logic [TEX_W-1:0]     o_vert_u,
    output logic [TEX_W-1:0]     o_vert_v,
    output logic [CORNER_W-1:0]  o_corner_index,
    output logic                 o_last_corner
);

    // camera vectors, q1.15
    t_cam   r_cam;
    t_side  side;
    t_basis basis;
    logic   basis_ready;
    logic   basis_valid;
    logic   emit_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam <= CAM_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_TOP_X:   r_cam.top[0]   <= i_cfg_data;
                CFG_TOP_Y:   r_cam.top[1]   <= i_cfg_data;
                CFG_TOP_Z:   r_cam.top[2]   <= i_cfg_data;
                CFG_RIGHT_X: r_cam.right[0] <= i_cfg_data;
                CFG_RIGHT_Y: r_cam.right[1] <= i_cfg_data;
                CFG_RIGHT_Z: r_cam.right[2] <= i_cfg_data;
                default: begin
                    // unused register index, write dropped
                end
            endcase
        end
    end

    // everything that rides along unchanged to the corner stage
    assign side.pos        = {i_pos_z, i_pos_y, i_pos_x};
    assign side.tex_left   = i_tex_left;
    assign side.tex_top    = i_tex_top;
    assign side.tex_right  = i_tex_right;
    assign side.tex_bottom = i_tex_bottom;
    assign side.color      = i_color;

    // the first basis stage takes a word whenever it can move
    assign busy = !basis_ready;

    bqe_basis u_basis (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (start),
        .i_side        (side),
        .i_half_width  (i_half_width),
        .i_half_height (i_half_height),
        .i_sin         (i_sin_angle),
        .i_cos         (i_cos_angle),
        .i_cam         (r_cam),
        .o_ready       (basis_ready),
        .o_valid       (basis_valid),
        .o_basis       (basis),
        .i_ready       (emit_ready)
    );

    bqe_emit u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (basis_valid),
        .i_basis        (basis),
        .o_ready        (emit_ready),
        .o_valid        (o_valid),
        .o_vert_x       (o_vert_x),
        .o_vert_y       (o_vert_y),
        .o_vert_z       (o_vert_z),
        .o_vert_color   (o_vert_color),
        .o_vert_u       (o_vert_u),
        .o_vert_v       (o_vert_v),
        .o_corner_index (o_corner_index),
        .o_last_corner  (o_last_corner)
    );

endmodule
`default_nettype wire

>>> tb/sv/billboard_quad_expander_tb.sv
// self-checking testbench for the billboard quad expander: particle words in, vertex words checked
`timescale 1ns / 100ps
module billboard_quad_expander_tb import bqe_pkg::*;;

    // run length guard and the settle time after the last vertex word
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          DRAIN_CYCLES = 12;
    localparam int          ROUND_SHIFT  = 30;
    localparam longint      COORD_MAX    = 64'sd2147483647;
    localparam longint      COORD_MIN    = -64'sd2147483648;
    localparam int          QUAD_CORNERS = 4;
    // register indexes past the camera vectors, writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    // one particle word as it sits on the input ports
    typedef struct packed {
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [POS_W-1:0] pos_z;
        logic [TEX_W-1:0] tex_left;
        logic [TEX_W-1:0] tex_top;
        logic [TEX_W-1:0] tex_right;
        logic [TEX_W-1:0] tex_bottom;
        logic [RAD_W-1:0] half_width;
        logic [RAD_W-1:0] half_height;
        logic [CLR_W-1:0] color;
        t_vec             sin_angle;
        t_vec             cos_angle;
    } t_particle;

    // one vertex word as it leaves the block
    typedef struct packed {
        logic [POS_W-1:0]    x;
        logic [POS_W-1:0]    y;
        logic [POS_W-1:0]    z;
        logic [CLR_W-1:0]    color;
        logic [TEX_W-1:0]    tex_u;
        logic [TEX_W-1:0]    tex_v;
        logic [CORNER_W-1:0] corner;
        logic                last;
    } t_vertex;

    logic                 i_clk;
    logic                 i_rst_n      = 1'b0;
    logic                 start        = 1'b0;
    logic                 busy;
    logic                 i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index  = CFG_TOP_X;
    logic [VEC_W-1:0]     i_cfg_data   = '0;
    logic                 o_valid;
    logic [POS_W-1:0]     o_vert_x;
    logic [POS_W-1:0]     o_vert_y;
    logic [POS_W-1:0]     o_vert_z;
    logic [CLR_W-1:0]     o_vert_color;
    logic [TEX_W-1:0]     o_vert_u;
    logic [TEX_W-1:0]     o_vert_v;
    logic [CORNER_W-1:0]  o_corner_index;
    logic                 o_last_corner;

    t_particle drive_word     = '0;
    t_particle particle_queue [$];
    t_vertex   vertex_expect  [$];
    t_vertex   head_vertex;
    logic      word_taken     = 1'b0;
    bit        sender_gaps_on = 1'b1;
    int        gap_left       = 0;
    int        fail_count     = 0;
    int        cycle_count    = 0;

    // camera mirror, index 0 is x
    t_vec cam_top   [AXES];
    t_vec cam_right [AXES];

    billboard_quad_expander dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_pos_x        (drive_word.pos_x),
        .i_pos_y        (drive_word.pos_y),
        .i_pos_z        (drive_word.pos_z),
        .i_tex_left     (drive_word.tex_left),
        .i_tex_top      (drive_word.tex_top),
        .i_tex_right    (drive_word.tex_right),
        .i_tex_bottom   (drive_word.tex_bottom),
        .i_half_width   (drive_word.half_width),
        .i_half_height  (drive_word.half_height),
        .i_color        (drive_word.color),
        .i_sin_angle    (drive_word.sin_angle),
        .i_cos_angle    (drive_word.cos_angle),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_valid        (o_valid),
        .o_vert_x       (o_vert_x),
        .o_vert_y       (o_vert_y),
        .o_vert_z       (o_vert_z),
        .o_vert_color   (o_vert_color),
        .o_vert_u       (o_vert_u),
        .o_vert_v       (o_vert_v),
        .o_corner_index (o_corner_index),
        .o_last_corner  (o_last_corner)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // (a*ta +/- b*tb) is exact q3.30, times the unsigned q15.16 radius, then round half up to q16.16
    function automatic longint rotated_axis(longint radius, longint a, longint ta,
                                            longint b, longint tb, bit negate);
        longint mix;
        mix = negate ? a * ta - b * tb : a * ta + b * tb;
        return (mix * radius + (longint'(1) <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
    endfunction

    // clamp an exact corner sum into the signed 32 bit coordinate range
    function automatic logic [POS_W-1:0] clamp_coord(longint v);
        if (v > COORD_MAX) begin
            return POS_MAX;
        end
        if (v < COORD_MIN) begin
            return POS_MIN;
        end
        return v[POS_W-1:0];
    endfunction

    // append one particle word to the sender's list
    function automatic void add_particle(input t_particle p);
        particle_queue.insert(particle_queue.size(), p);
    endfunction

    // work out the four vertex words of one particle with the camera as it stands now
    task automatic expand_quad(input t_particle p);
        longint      centre [AXES];
        longint      vr     [AXES];
        longint      vt     [AXES];
        longint      hw, hh, sn, cs, acc;
        logic [POS_W-1:0] coord [AXES];
        t_vertex     vx;
        hw = longint'(p.half_width);
        hh = longint'(p.half_height);
        sn = longint'($signed(p.sin_angle));
        cs = longint'($signed(p.cos_angle));
        centre[0] = longint'($signed(p.pos_x));
        centre[1] = longint'($signed(p.pos_y));
        centre[2] = longint'($signed(p.pos_z));
        for (int i = 0; i < AXES; i++) begin
            vr[i] = rotated_axis(hw, sn, cam_top[i], cs, cam_right[i], 1'b0);
            vt[i] = rotated_axis(hh, cs, cam_top[i], sn, cam_right[i], 1'b1);
        end
        // corner bit 0 picks the sign of the top term, bit 1 the sign of the right term
        for (int k = 0; k < QUAD_CORNERS; k++) begin
            for (int i = 0; i < AXES; i++) begin
                acc = centre[i] + (k[0] ? vt[i] : -vt[i]) + (k[1] ? vr[i] : -vr[i]);
                coord[i] = clamp_coord(acc);
            end
            vx.x      = coord[0];
            vx.y      = coord[1];
            vx.z      = coord[2];
            vx.color  = p.color;
            vx.tex_u  = k[1] ? p.tex_right : p.tex_left;
            vx.tex_v  = k[0] ? p.tex_top : p.tex_bottom;
            vx.corner = k[CORNER_W-1:0];
            vx.last   = (vx.corner == CORNER_LAST);
            vertex_expect.insert(vertex_expect.size(), vx);
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            fail_count++;
        end
    endtask

    // sender gaps: mostly none or short, now and then a long one
    function automatic int next_gap();
        int unsigned roll;
        if (!sender_gaps_on) begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 50) begin
            return 0;
        end
        if (roll < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // driver: holds a particle word with start high until it is taken, then gaps or moves on
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || word_taken) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                start    <= 1'b0;
            end else if (particle_queue.size() > 0) begin
                drive_word <= particle_queue.pop_front();
                start      <= 1'b1;
                gap_left   <= next_gap();
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: tracks camera writes, predicts on each taken particle, checks each vertex word
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            word_taken <= 1'b0;
            cam_top    = '{16'sd0, 16'sd32767, 16'sd0};
            cam_right  = '{16'sd32767, 16'sd0, 16'sd0};
        end else begin
            word_taken <= start && !busy;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_TOP_X:   cam_top[0]   = i_cfg_data;
                    CFG_TOP_Y:   cam_top[1]   = i_cfg_data;
                    CFG_TOP_Z:   cam_top[2]   = i_cfg_data;
                    CFG_RIGHT_X: cam_right[0] = i_cfg_data;
                    CFG_RIGHT_Y: cam_right[1] = i_cfg_data;
                    CFG_RIGHT_Z: cam_right[2] = i_cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy) begin
                expand_quad(drive_word);
            end
            if (o_valid) begin
                if (vertex_expect.size() == 0) begin
                    $error("vertex word with no particle pending, corner %0d", o_corner_index);
                    fail_count++;
                end else begin
                    head_vertex = vertex_expect.pop_front();
                    compare_field("vert_x", head_vertex.x, o_vert_x);
                    compare_field("vert_y", head_vertex.y, o_vert_y);
                    compare_field("vert_z", head_vertex.z, o_vert_z);
                    compare_field("vert_color", head_vertex.color, o_vert_color);
                    compare_field("vert_u", head_vertex.tex_u, o_vert_u);
                    compare_field("vert_v", head_vertex.tex_v, o_vert_v);
                    compare_field("corner_index", head_vertex.corner, o_corner_index);
                    compare_field("last_corner", head_vertex.last, o_last_corner);
                end
            end
        end
    end

    function automatic t_particle make_particle(
        logic [31:0] px, logic [31:0] py, logic [31:0] pz,
        logic [15:0] tl, logic [15:0] tt, logic [15:0] tr, logic [15:0] tb,
        logic [30:0] hw, logic [30:0] hh, logic [31:0] clr,
        logic [15:0] sn, logic [15:0] cs);
        t_particle p;
        p = '{px, py, pz, tl, tt, tr, tb, hw, hh, clr, sn, cs};
        return p;
    endfunction

    // random particle: full range fields mixed with small positions and radii
    function automatic t_particle random_particle();
        t_particle p;
        p.pos_x = $urandom;
        p.pos_y = $urandom;
        p.pos_z = $urandom;
        if ($urandom_range(0, 2) != 0) begin
            p.pos_x = 32'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
            p.pos_y = 32'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
            p.pos_z = 32'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
        end
        if ($urandom_range(0, 3) == 0) begin
            p.half_width  = RAD_W'($urandom);
            p.half_height = RAD_W'($urandom);
        end else begin
            p.half_width  = RAD_W'($urandom_range(0, 32'h0010_0000));
            p.half_height = RAD_W'($urandom_range(0, 32'h0010_0000));
        end
        // mostly legal texture coordinates, sometimes above 1.0
        if ($urandom_range(0, 7) == 0) begin
            p.tex_left   = TEX_W'($urandom);
            p.tex_top    = TEX_W'($urandom);
            p.tex_right  = TEX_W'($urandom);
            p.tex_bottom = TEX_W'($urandom);
        end else begin
            p.tex_left   = TEX_W'($urandom_range(0, 32768));
            p.tex_top    = TEX_W'($urandom_range(0, 32768));
            p.tex_right  = TEX_W'($urandom_range(0, 32768));
            p.tex_bottom = TEX_W'($urandom_range(0, 32768));
        end
        p.color     = $urandom;
        p.sin_angle = VEC_W'($urandom);
        p.cos_angle = VEC_W'($urandom);
        return p;
    endfunction

    // wait until every word went in and every vertex came out, then let the pipe settle
    task automatic wait_idle();
        do begin
            @(posedge i_clk);
        end while (particle_queue.size() != 0 || start || vertex_expect.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input t_vec data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
    endtask

    // load all six camera components, then hit a spare index that must change nothing
    task automatic set_camera(input t_vec tx, input t_vec ty, input t_vec tz,
                              input t_vec rx, input t_vec ry, input t_vec rz);
        write_reg(CFG_TOP_X, tx);
        write_reg(CFG_TOP_Y, ty);
        write_reg(CFG_TOP_Z, tz);
        write_reg(CFG_RIGHT_X, rx);
        write_reg(CFG_RIGHT_Y, ry);
        write_reg(CFG_RIGHT_Z, rz);
        write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, t_vec'($urandom));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic queue_random(input int count);
        repeat (count) add_particle(random_particle());
    endtask

    // stimulus and end of run
    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset camera: upright, unit square, rotations, saturation, texture pass-through
        add_particle(make_particle(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_particle(make_particle(0, 0, 0, 16'h0000, 16'h0000, 16'h8000,
            16'h8000, 31'h0001_0000, 31'h0001_0000, 32'hFFFF_FFFF, 16'h0000, 16'h7FFF));
        add_particle(make_particle(32'h0001_0000, 32'hFFFF_0000, 0, 16'h1000,
            16'h2000, 16'h3000, 16'h4000, 31'h0002_0000, 31'h0000_8000, 32'hA5A5_A5A5,
            16'h7FFF, 16'h0000));
        add_particle(make_particle(32'hFFFE_8000, 32'hFFFF_C000, 32'hFFFF_FFFF,
            16'h8000, 16'h0000, 16'h0000, 16'h8000, 31'h0001_0000, 31'h0001_0000,
            32'h1234_5678, 16'h8000, 16'h8000));
        add_particle(make_particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
            0, 0, 16'h8000, 16'h8000, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h0F0F_0F0F,
            16'h0000, 16'h7FFF));
        add_particle(make_particle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            0, 0, 16'h8000, 16'h8000, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'hF0F0_F0F0,
            16'h0000, 16'h7FFF));
        add_particle(make_particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
            16'h8000, 16'h8000, 16'h8000, 16'h8000, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
            32'hFFFF_0000, 16'h8000, 16'h8000));
        add_particle(make_particle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            0, 0, 0, 0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h0000_FFFF, 16'h8000, 16'h7FFF));
        add_particle(make_particle(0, 0, 0, 16'hFFFF, 16'h8001, 16'hFFFF,
            16'h8001, 31'h0000_4000, 31'h0000_4000, 32'h5A5A_5A5A, 16'h4000, 16'h4000));
        add_particle(make_particle(32'h0000_8000, 0, 0, 16'h0100, 16'h0200,
            16'h0300, 16'h0400, 31'h7FFF_FFFF, 31'h0000_0000, 32'h8000_0001,
            16'h5A82, 16'h5A82));
        add_particle(make_particle(0, 32'h0000_8000, 0, 16'h7FFF, 16'h0001,
            16'h0001, 16'h7FFF, 31'h0000_0000, 31'h7FFF_FFFF, 32'h7FFF_FFFE,
            16'hA57E, 16'h5A82));
        add_particle(make_particle(32'h4000_0000, 32'hC000_0000, 32'h1234_5678,
            16'h2000, 16'h6000, 16'h6000, 16'h2000, 31'h4000_0000, 31'h4000_0000,
            32'hDEAD_0000, 16'h7FFF, 16'h7FFF));
        add_particle(make_particle(0, 0, 0, 0, 0, 0, 0, 31'h0000_0001,
            31'h0000_0001, 32'h0000_0000, 16'h7FFF, 16'h7FFF));
        add_particle(make_particle(32'hFFFF_FFFF, 32'h0000_0001, 0, 16'h8000,
            16'h8000, 0, 0, 31'h0000_8000, 31'h0000_8000, 32'h0123_4567,
            16'h4000, 16'hC000));
        queue_random(20);
        wait_idle();

        // camera at the positive corner, back to back words
        sender_gaps_on = 1'b0;
        set_camera(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        add_particle(make_particle(32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0, 0,
            31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 16'h7FFF, 16'h7FFF));
        queue_random(30);
        wait_idle();

        // camera at the negative corner: round half up on both signs, widest products
        sender_gaps_on = 1'b1;
        set_camera(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        add_particle(make_particle(0, 0, 0, 0, 0, 0, 0, 31'h0000_0001,
            31'h0000_0003, 32'h1111_1111, 16'h4000, 16'h0000));
        add_particle(make_particle(0, 0, 0, 0, 0, 0, 0, 31'h0000_0001,
            31'h0000_0001, 32'h2222_2222, 16'hC000, 16'h0000));
        add_particle(make_particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
            0, 0, 0, 0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h3333_3333, 16'h8000, 16'h8000));
        add_particle(make_particle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            0, 0, 0, 0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h4444_4444, 16'h7FFF, 16'h8000));
        queue_random(30);
        wait_idle();

        // mixed extremes with a tilted right vector
        set_camera(16'sh8000, 16'sh7FFF, 16'sh0000, 16'sh7FFF, 16'sh8000, -16'sd1);
        queue_random(30);
        wait_idle();

        // random cameras, one run without sender gaps and one with
        sender_gaps_on = 1'b0;
        set_camera(t_vec'($urandom), t_vec'($urandom), t_vec'($urandom),
                   t_vec'($urandom), t_vec'($urandom), t_vec'($urandom));
        queue_random(25);
        wait_idle();

        sender_gaps_on = 1'b1;
        set_camera(t_vec'($urandom), t_vec'($urandom), t_vec'($urandom),
                   t_vec'($urandom), t_vec'($urandom), t_vec'($urandom));
        queue_random(25);
        wait_idle();

        // written back to the power-up camera
        set_camera(16'sh0000, 16'sh7FFF, 16'sh0000, 16'sh7FFF, 16'sh0000, 16'sh0000);
        queue_random(20);
        wait_idle();

        if (fail_count == 0 && vertex_expect.size() == 0) begin
            $display("billboard_quad_expander test passed");
        end else begin
            $display("billboard_quad_expander test failed");
        end
        $finish;
    end

    // watchdog on a stuck handshake or missing vertex words
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("billboard_quad_expander test failed");
        $finish;
    end

endmodule
